// ===== hw/rtl/colormap_linear_interpolator_unit_assert.svh =====
// Assertion macros for the colormap lookup port checker.
`ifndef COLORMAP_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define COLORMAP_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CLI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colormap lookup: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define CLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colormap lookup: next-cycle check failed");

`endif

// ===== hw/rtl/cli_pkg.sv =====
// Shared types and constants of the colormap lookup unit.
`timescale 1ns / 1ps

package cli_pkg;

  // Field widths.
  localparam int DATA_W   = 16;
  localparam int IDX_IN_W = 4;
  localparam int CNT_W    = 5;
  localparam int NUM_CH   = 4;
  localparam int CH_W     = 2;

  // Arithmetic widths: diff of two Q0.16 values, weight with 16 fraction bits.
  localparam int DIFF_W     = DATA_W + 1;
  localparam int DIVIDEND_W = 2 * DATA_W;
  localparam int DIVISOR_W  = DATA_W;
  localparam int DIV_CNT_W  = 6;
  localparam int W_W        = DIVIDEND_W + 1;
  localparam int PROD_W     = W_W + DIFF_W;
  localparam int ACC_W      = PROD_W + 1;

  localparam logic [DATA_W-1:0] ROUND_HALF = 16'h8000;
  localparam logic [DATA_W-1:0] CH_MAX     = 16'hFFFF;

  // Item operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef logic [NUM_CH-1:0][DATA_W-1:0] cli_color_t;

  // One breakpoint as held in the table: red in color[0] up to alpha in color[3].
  typedef struct packed {
    cli_color_t        color;
    logic [DATA_W-1:0] x;
  } cli_entry_t;

  localparam int ENTRY_W = $bits(cli_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LEFT,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } cli_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } cli_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } cli_div_rsp_t;

  typedef struct packed {
    logic                  mul_en;
    logic signed [W_W-1:0] weight;
    logic [DATA_W-1:0]     c0;
    logic [DATA_W-1:0]     c1;
  } cli_blend_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              clip;
  } cli_blend_rsp_t;

endpackage

// ===== hw/rtl/cli_ifs.sv =====
// Valid/ready channel interfaces for the lookup items and the result items.
`timescale 1ns / 1ps

interface cli_in_if;
  import cli_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [IDX_IN_W-1:0] point_index;
  logic [DATA_W-1:0]   point_x;
  logic [DATA_W-1:0]   point_red;
  logic [DATA_W-1:0]   point_green;
  logic [DATA_W-1:0]   point_blue;
  logic [DATA_W-1:0]   point_alpha;
  logic [DATA_W-1:0]   position;

  modport source (
    output valid, op, point_index, point_x, point_red, point_green,
           point_blue, point_alpha, position,
    input  ready
  );

  modport sink (
    input  valid, op, point_index, point_x, point_red, point_green,
           point_blue, point_alpha, position,
    output ready
  );
endinterface

interface cli_out_if;
  import cli_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] red;
  logic [DATA_W-1:0] green;
  logic [DATA_W-1:0] blue;
  logic [DATA_W-1:0] alpha;
  logic              clipped;
  logic              map_missing;

  modport source (
    output valid, red, green, blue, alpha, clipped, map_missing,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha, clipped, map_missing,
    output ready
  );
endinterface

// ===== hw/rtl/cli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/cli_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module cli_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cli_pkg::cli_div_req_t req,
  output cli_pkg::cli_div_rsp_t rsp
);
  import cli_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  divisor_r, divisor_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One shift-subtract step: bring in the next dividend bit and try the divisor.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = (trial >= {1'b0, divisor_r});

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = DIV_CNT_W'(DIVIDEND_W);
      quo_nxt     = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/cli_blend.sv =====
// Shared blend unit: weight times color step, then round and saturate.
`timescale 1ns / 1ps

module cli_blend (
  input  logic                    clk,
  input  cli_pkg::cli_blend_req_t req,
  output cli_pkg::cli_blend_rsp_t rsp
);
  import cli_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] w_ext;
  logic signed [PROD_W-1:0] d_ext;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0]        base_r, base_nxt;
  logic signed [ACC_W-1:0]  base_term;
  logic signed [ACC_W-1:0]  sum;

  // Multiply stage: weight times the channel step between the two colors.
  assign diff     = $signed({1'b0, req.c1}) - $signed({1'b0, req.c0});
  assign w_ext    = PROD_W'(req.weight);
  assign d_ext    = PROD_W'(diff);
  assign prod_nxt = req.mul_en ? w_ext * d_ext : prod_r;
  assign base_nxt = req.mul_en ? req.c0 : base_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    base_r <= base_nxt;
  end

  // Add stage: left color scaled up plus one half for rounding.
  assign base_term = $signed({(ACC_W - 2 * DATA_W)'(0), base_r, ROUND_HALF});
  assign sum       = ACC_W'(prod_r) + base_term;

  // Saturate to the unsigned channel range.
  always_comb begin
    priority if (sum[ACC_W-1]) begin
      rsp.value = '0;
      rsp.clip  = 1'b1;
    end else if (|sum[ACC_W-2:2*DATA_W]) begin
      rsp.value = CH_MAX;
      rsp.clip  = 1'b1;
    end else begin
      rsp.value = sum[2*DATA_W-1:DATA_W];
      rsp.clip  = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/colormap_linear_interpolator_unit.sv =====
// Top level of the piecewise linear colormap lookup unit.
// A load item is written into the table on acceptance and the unit stays ready.
// A lookup walks k breakpoints (1 to MAX_POINTS-1), then divides for the weight and
// blends four channels; a zero-width segment skips the division, and with no map the
// lookup goes straight to its result. The one-bit-per-cycle divider and the walk, one entry per cycle, dominate.
// Reset clears the sequencer and point_count; breakpoint slots are undefined until loaded.
`timescale 1ns / 1ps

module colormap_linear_interpolator_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cli_pkg::CNT_W-1:0] cfg_data,
  cli_in_if.sink                   in_chan,
  cli_out_if.source                out_chan
);
  import cli_pkg::*;

  localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int N_W    = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
  localparam int SLOT_W = (IDX_IN_W > IDX_W + 1) ? IDX_IN_W : IDX_W + 1;

  cli_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [DATA_W-1:0] x1_r, x1_nxt;
  cli_color_t        c0_r, c0_nxt;
  cli_color_t        c1_r, c1_nxt;
  logic              neg_r, neg_nxt;
  logic signed [W_W-1:0] w_r, w_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  cli_color_t        res_r, res_nxt;
  logic              clip_r, clip_nxt;
  logic              missing_r, missing_nxt;

  logic [N_W-1:0]    n_ext;
  logic [N_W-1:0]    n_eff;
  logic [SLOT_W-1:0] slot_ext;
  logic              ram_we;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  cli_entry_t        wr_entry;
  cli_entry_t        rd_entry;
  logic [DIFF_W-1:0] num;
  logic [DIFF_W-1:0] den;
  logic [DIFF_W-1:0] num_abs;
  logic [DIFF_W-1:0] den_abs;
  cli_div_req_t      div_req;
  cli_div_rsp_t      div_rsp;
  cli_blend_req_t    blend_req;
  cli_blend_rsp_t    blend_rsp;

  // Breakpoints in use, clamped to the table size.
  assign n_ext = N_W'(count_r);
  assign n_eff = (n_ext > N_W'(MAX_POINTS)) ? N_W'(MAX_POINTS) : n_ext;

  // Breakpoint table write on a load item; slots beyond the table are dropped.
  assign slot_ext = SLOT_W'(in_chan.point_index);
  assign ram_we   = (state_r == ST_IDLE) && in_chan.valid && (in_chan.op == OP_LOAD) &&
                    (slot_ext < SLOT_W'(MAX_POINTS));
  assign wr_entry.x     = in_chan.point_x;
  assign wr_entry.color = {in_chan.point_alpha, in_chan.point_blue,
                           in_chan.point_green, in_chan.point_red};
  assign rd_entry = cli_entry_t'(ram_rdata);

  cli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_cli_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_ext[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Offsets of the position and of the right end point from the left end point.
  assign num     = {1'b0, pos_r} - {1'b0, rd_entry.x};
  assign den     = {1'b0, x1_r} - {1'b0, rd_entry.x};
  assign num_abs = num[DIFF_W-1] ? -num : num;
  assign den_abs = den[DIFF_W-1] ? -den : den;

  assign div_req.start    = (state_r == ST_LEFT) && (den != '0);
  assign div_req.dividend = {num_abs[DATA_W-1:0], DATA_W'(0)};
  assign div_req.divisor  = den_abs[DATA_W-1:0];

  cli_divider u_cli_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign blend_req.mul_en = (state_r == ST_MUL);
  assign blend_req.weight = w_r;
  assign blend_req.c0     = c0_r[ch_r];
  assign blend_req.c1     = c1_r[ch_r];

  cli_blend u_cli_blend (
    .clk (clk),
    .req (blend_req),
    .rsp (blend_rsp)
  );

  // Sequencer: segment walk, weight division (skipped for a zero-width segment), then four channel blends.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = cfg_we ? cfg_data : count_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    x1_nxt      = x1_r;
    c0_nxt      = c0_r;
    c1_nxt      = c1_r;
    neg_nxt     = neg_r;
    w_nxt       = w_r;
    ch_nxt      = ch_r;
    res_nxt     = res_r;
    clip_nxt    = clip_r;
    missing_nxt = missing_r;
    rd_addr     = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = IDX_W'(1);
        if (in_chan.valid && (in_chan.op == OP_LOOKUP)) begin
          pos_nxt     = in_chan.position;
          idx_nxt     = '0;
          last_nxt    = IDX_W'(n_eff - N_W'(2));
          clip_nxt    = 1'b0;
          missing_nxt = 1'b0;
          if (n_eff < N_W'(2)) begin
            res_nxt     = '0;
            missing_nxt = 1'b1;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end

      // The read data holds the breakpoint right of the current segment.
      ST_WALK: begin
        if ((pos_r >= rd_entry.x) && (idx_r != last_r)) begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_r + IDX_W'(1) + IDX_W'(1);
        end else begin
          x1_nxt    = rd_entry.x;
          c1_nxt    = rd_entry.color;
          rd_addr   = idx_r;
          state_nxt = ST_LEFT;
        end
      end

      // Left breakpoint arrives; a zero-width segment skips the division.
      ST_LEFT: begin
        c0_nxt  = rd_entry.color;
        neg_nxt = num[DIFF_W-1] ^ den[DIFF_W-1];
        ch_nxt  = '0;
        if (den == '0) begin
          w_nxt     = '0;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          w_nxt     = neg_r ? -$signed({1'b0, div_rsp.quotient})
                            : $signed({1'b0, div_rsp.quotient});
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        res_nxt[ch_r] = blend_rsp.value;
        clip_nxt      = clip_r | blend_rsp.clip;
        if (ch_r == CH_W'(NUM_CH - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_MUL;
        end
      end

      ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers and result holding registers.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    last_r    <= last_nxt;
    x1_r      <= x1_nxt;
    c0_r      <= c0_nxt;
    c1_r      <= c1_nxt;
    neg_r     <= neg_nxt;
    w_r       <= w_nxt;
    ch_r      <= ch_nxt;
    res_r     <= res_nxt;
    clip_r    <= clip_nxt;
    missing_r <= missing_nxt;
  end

  // Channel handshakes.
  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_OUT);
  assign out_chan.red         = res_r[0];
  assign out_chan.green       = res_r[1];
  assign out_chan.blue        = res_r[2];
  assign out_chan.alpha       = res_r[3];
  assign out_chan.clipped     = clip_r;
  assign out_chan.map_missing = missing_r;

endmodule

// ===== hw/rtl/cli_checker.sv =====
// Port-level checker of the colormap lookup unit and its bind.
`timescale 1ns / 1ps

`include "colormap_linear_interpolator_unit_assert.svh"

module cli_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cli_pkg::DATA_W-1:0] out_red,
  input logic [cli_pkg::DATA_W-1:0] out_green,
  input logic [cli_pkg::DATA_W-1:0] out_blue,
  input logic [cli_pkg::DATA_W-1:0] out_alpha,
  input logic                       out_clipped,
  input logic                       out_map_missing
);
  import cli_pkg::*;

  // A pending result blocks new items.
  `CLI_ASSERT_SAME(a_busy_while_result, out_valid, !in_ready)

  // Without a map the color is all zero and nothing is clipped.
  `CLI_ASSERT_SAME(a_missing_is_black, out_valid && out_map_missing, (out_red == '0) && (out_green == '0) && (out_blue == '0) && (out_alpha == '0) && !out_clipped)

  // A lookup item occupies the unit for at least the next cycle.
  `CLI_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (in_op == OP_LOOKUP), !in_ready)

  // A stalled result item holds.
  `CLI_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha) && $stable(out_clipped) && $stable(out_map_missing))

endmodule

bind colormap_linear_interpolator_unit cli_checker u_cli_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_op           (in_chan.op),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_red         (out_chan.red),
  .out_green       (out_chan.green),
  .out_blue        (out_chan.blue),
  .out_alpha       (out_chan.alpha),
  .out_clipped     (out_chan.clipped),
  .out_map_missing (out_chan.map_missing)
);

// ===== sim/cli_lookup_checker.sv =====
// Scoreboard that predicts every colormap lookup result and checks it against the unit.
`timescale 1ns / 1ps

module cli_lookup_checker #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cli_pkg::CNT_W-1:0] cfg_data,
  cli_in_if                        in_mon,
  cli_out_if                       out_mon,
  output int                       error_count,
  output int                       colors_pending
);
  import cli_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] red;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] blue;
    logic [DATA_W-1:0] alpha;
    logic              clipped;
    logic              map_missing;
  } lookup_color_t;

  // Shadow copy of the breakpoint table and the point count register.
  logic [DATA_W-1:0] shadow_x [MAX_POINTS];
  cli_color_t        shadow_color [MAX_POINTS];
  logic [CNT_W-1:0]  shadow_count;
  lookup_color_t     expected_colors [$];

  initial begin
    error_count    = 0;
    colors_pending = 0;
    shadow_count   = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      shadow_x[k]     = '0;
      shadow_color[k] = '0;
    end
  end

  // Segment walk, signed weight and per-channel blend with saturation.
  function automatic lookup_color_t color_at(input logic [DATA_W-1:0] pos);
    lookup_color_t res;
    int unsigned   used;
    int unsigned   seg;
    bit            walking;
    longint        num;
    longint        den;
    longint        mag;
    longint        weight;
    longint        c0;
    longint        c1;
    longint        acc;
    longint        level;
    logic [DATA_W-1:0] chan [NUM_CH];

    res  = '0;
    used = (shadow_count > MAX_POINTS) ? MAX_POINTS : shadow_count;
    if (used < 2) begin
      res.map_missing = 1'b1;
      return res;
    end

    // Walk from the first segment, clamped to the last one in use.
    seg     = 0;
    walking = 1'b1;
    while (walking && shadow_x[seg + 1] <= pos) begin
      seg++;
      if (seg > used - 2) begin
        seg     = used - 2;
        walking = 1'b0;
      end
    end

    // A zero-width segment keeps the weight at zero, so the left color wins.
    num = longint'(pos) - longint'(shadow_x[seg]);
    den = longint'(shadow_x[seg + 1]) - longint'(shadow_x[seg]);
    if (den == 0) begin
      weight = 0;
    end else begin
      mag    = ((num < 0) ? -num : num) <<< 16;
      mag    = mag / ((den < 0) ? -den : den);
      weight = ((num < 0) != (den < 0)) ? -mag : mag;
    end

    for (int ch = 0; ch < NUM_CH; ch++) begin
      c0  = longint'(shadow_color[seg][ch]);
      c1  = longint'(shadow_color[seg + 1][ch]);
      acc = c0 * 65536 + weight * (c1 - c0) + 32768;
      if (acc < 0) begin
        chan[ch]    = '0;
        res.clipped = 1'b1;
      end else begin
        level = acc >>> 16;
        if (level > 65535) begin
          chan[ch]    = CH_MAX;
          res.clipped = 1'b1;
        end else begin
          chan[ch] = level[DATA_W-1:0];
        end
      end
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    res.alpha = chan[3];
    return res;
  endfunction

  // Only the first ten failures are printed; the rest are counted.
  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // All bookkeeping happens on the rising edge, where the channels are stable.
  always @(posedge clk) begin
    lookup_color_t want;
    lookup_color_t got;

    if (!rst_n) begin
      shadow_count = '0;
      expected_colors.delete();
    end else begin
      if (cfg_we) shadow_count = cfg_data;

      // Compare a delivered result item with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got.red         = out_mon.red;
        got.green       = out_mon.green;
        got.blue        = out_mon.blue;
        got.alpha       = out_mon.alpha;
        got.clipped     = out_mon.clipped;
        got.map_missing = out_mon.map_missing;
        if (expected_colors.size() == 0) begin
          note_failure($sformatf("unexpected result rgba=%h %h %h %h clip=%b missing=%b",
                                 got.red, got.green, got.blue, got.alpha,
                                 got.clipped, got.map_missing));
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.clipped !== want.clipped || got.map_missing !== want.map_missing) begin
            note_failure($sformatf({"result mismatch: expected rgba=%h %h %h %h clip=%b ",
                                    "missing=%b, got rgba=%h %h %h %h clip=%b missing=%b"},
                                   want.red, want.green, want.blue, want.alpha,
                                   want.clipped, want.map_missing,
                                   got.red, got.green, got.blue, got.alpha,
                                   got.clipped, got.map_missing));
          end
        end
      end

      // An accepted load updates the table; an accepted lookup queues its color.
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_LOAD) begin
          if (int'(in_mon.point_index) < MAX_POINTS) begin
            shadow_x[in_mon.point_index]     = in_mon.point_x;
            shadow_color[in_mon.point_index] = {in_mon.point_alpha, in_mon.point_blue,
                                                in_mon.point_green, in_mon.point_red};
          end
        end else begin
          expected_colors = {expected_colors, color_at(in_mon.position)};
        end
      end
    end
    colors_pending = expected_colors.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives breakpoint loads, lookups and point counts, then reports the verdict.
`timescale 1ns / 1ps

module tb_top;
  import cli_pkg::*;

  localparam int ITEM_TARGET = 900;
  localparam int SETTLE      = 64;
  localparam int CYCLE_LIMIT = 500000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  int               error_count;
  int               colors_pending;
  int unsigned      cycle_count;
  int               items_sent;
  bit               calm;
  logic [DATA_W-1:0] map_x [16];

  cli_in_if  in_chan ();
  cli_out_if out_chan ();

  colormap_linear_interpolator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cli_lookup_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .error_count    (error_count),
    .colors_pending (colors_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL colormap_linear_interpolator_unit");
      $finish;
    end
  end

  // Result side: random stall bursts, none once the run turns calm.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
  end

  function automatic logic [DATA_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cli_color_t random_color();
    return {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
  endfunction

  // Lookup positions favor the ends of the range and the breakpoints themselves.
  function automatic logic [DATA_W-1:0] pick_position(input int used);
    int j;
    j = (used > 0) ? $urandom_range(0, used - 1) : 0;
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return map_x[j];
      4:       return map_x[j] + 16'd1;
      5:       return map_x[j] - 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic op, input logic [IDX_IN_W-1:0] slot,
                           input logic [DATA_W-1:0] x, input cli_color_t color,
                           input logic [DATA_W-1:0] pos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_chan.op          <= op;
    in_chan.point_index <= slot;
    in_chan.point_x     <= x;
    in_chan.point_red   <= color[0];
    in_chan.point_green <= color[1];
    in_chan.point_blue  <= color[2];
    in_chan.point_alpha <= color[3];
    in_chan.position    <= pos;
    in_chan.valid       <= 1'b1;
    if (op == OP_LOAD) map_x[slot] = x;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop sending until every predicted result is out, then let the unit settle.
  task automatic drain(input int settle);
    in_chan.valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_point_count(input logic [CNT_W-1:0] value);
    drain(SETTLE);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int               phase;
    int               used;
    int               slot;
    int               run_len;
    int               room;
    int               x;
    bit               broken;
    logic [CNT_W-1:0] count;

    // Every input starts at a known value.
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.op          = OP_LOAD;
    in_chan.point_index = '0;
    in_chan.point_x     = '0;
    in_chan.point_red   = '0;
    in_chan.point_green = '0;
    in_chan.point_blue  = '0;
    in_chan.point_alpha = '0;
    in_chan.position    = '0;
    items_sent          = 0;
    for (int k = 0; k < 16; k++) map_x[k] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With no points and with a single point there is no map.
    send_item(OP_LOOKUP, 4'd0, 16'h0000, '0, 16'hFFFF);
    write_point_count(5'd1);
    send_item(OP_LOOKUP, 4'd15, 16'hFFFF, '1, 16'h0000);

    // Four breakpoints; the middle two share a position to form a zero-width segment.
    send_item(OP_LOAD, 4'd0, 16'h2000, {16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000}, 16'h0);
    send_item(OP_LOAD, 4'd1, 16'hE000, {16'h0000, 16'hFEDC, 16'h0000, 16'hFFFF}, 16'h0);
    send_item(OP_LOAD, 4'd2, 16'hE000, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 16'h0);
    send_item(OP_LOAD, 4'd3, 16'hFFFF, {16'hAAAA, 16'h5555, 16'hFFFE, 16'h0001}, 16'h0);

    // Two points: extrapolation on both sides, an exact hit and a midpoint.
    write_point_count(5'd2);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'h0000);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'h2000);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'h8000);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'hFFFF);

    // Three points: the last segment has zero width and yields the left color.
    write_point_count(5'd3);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'hF000);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'hE000);

    // Four points, then the last one moved below its neighbor.
    write_point_count(5'd4);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'hF000);
    send_item(OP_LOAD, 4'd3, 16'h1000, {16'hAAAA, 16'h5555, 16'hFFFE, 16'h0001}, 16'h0);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'hF000);
    send_item(OP_LOOKUP, 4'd0, 16'h0, '0, 16'h0800);

    // Random part: each phase sets a count, fills the slots in use, then mixes items.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: count = 5'd31;
        1: count = 5'd0;
        2: count = 5'd16;
        3: count = 5'd2;
        default: begin
          case ($urandom_range(0, 9))
            0:       count = 5'($urandom_range(0, 1));
            1:       count = 5'($urandom_range(17, 31));
            2:       count = 5'd16;
            default: count = 5'($urandom_range(2, 15));
          endcase
        end
      endcase
      if (items_sent > ITEM_TARGET * 7 / 8) calm = 1'b1;
      write_point_count(count);
      used = (count > 16) ? 16 : int'(count);

      // Ascending positions with random steps, now and then a scrambled set.
      broken = ($urandom_range(0, 7) == 0);
      x = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4000);
      for (slot = 0; used >= 2 && slot < used; slot++) begin
        if (broken) begin
          x = $urandom_range(0, 65535);
        end else if (slot > 0) begin
          room = (65535 - x) / (used - slot);
          if (room > 0 && $urandom_range(0, 9) != 0) x += $urandom_range(1, room);
        end
        send_item(OP_LOAD, 4'(slot), 16'(x), random_color(),
                  16'($urandom_range(0, 65535)));
      end

      // Mostly lookups; stray loads to any slot reshape the map on the fly.
      run_len = $urandom_range(15, 45);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          slot = $urandom_range(0, 15);
          send_item(OP_LOAD, 4'(slot), pick_channel(), random_color(),
                    16'($urandom_range(0, 65535)));
        end else begin
          send_item(OP_LOOKUP, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                    random_color(), pick_position(used));
        end
        if ($urandom_range(0, 59) == 0) drain(1);
      end
      phase++;
    end

    drain(SETTLE);
    if (error_count == 0 && colors_pending == 0) begin
      $display("PASS colormap_linear_interpolator_unit");
    end else begin
      $display("FAIL colormap_linear_interpolator_unit");
    end
    $finish;
  end

endmodule
